FILE: sv/ngp_pkg.sv
`default_nettype none
package ngp_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // classified stream beat
    typedef struct packed {
        logic [7:0] ch;
        logic       is_digit;
        logic       is_dot;
        logic       is_minus;
        logic       is_plus;
        logic       is_comma;
        logic       is_star;
        logic       is_dollar;
        logic       hex_ok;
        logic [3:0] hex_val;
    } beat_t;

    // control for one numeric field accumulator
    typedef struct packed {
        logic       load_empty;
        logic       feed;
        logic       clear;
        logic       fin;
        logic       lead;
        logic       point;
        logic       sign;
        logic       nonempty;
        logic [2:0] frac_cnt;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_dot;
        logic       is_minus;
        logic       is_plus;
    } num_ctl_t;

    typedef struct packed {
        logic set_point;
        logic set_sign;
        logic inc_frac;
        logic stop;
    } num_act_t;

    function automatic logic [23:0] pow10(input logic [2:0] e);
        logic [23:0] r;
        case (e)
            3'd0: r = 24'd1;
            3'd1: r = 24'd10;
            3'd2: r = 24'd100;
            3'd3: r = 24'd1000;
            3'd4: r = 24'd10000;
            3'd5: r = 24'd100000;
            3'd6: r = 24'd1000000;
            default: r = 24'd10000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/ngp_front.sv
`default_nettype none
module ngp_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    in_byte,
    output logic               q_valid,
    output ngp_pkg::beat_t     q_beat,
    input  wire logic          q_pop
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    ngp_pkg::beat_t            cls;
    ngp_pkg::beat_t            queue_reg [DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]            cnt_reg, cnt_next;
    logic                      push;

    always_comb
    begin
        cls          = '0;
        cls.ch       = in_byte;
        cls.is_digit = (in_byte >= ngp_pkg::CH_ZERO) && (in_byte <= 8'h39);
        cls.is_dot   = in_byte == ngp_pkg::CH_DOT;
        cls.is_minus = in_byte == ngp_pkg::CH_MINUS;
        cls.is_plus  = in_byte == ngp_pkg::CH_PLUS;
        cls.is_comma = in_byte == ngp_pkg::CH_COMMA;
        cls.is_star  = in_byte == ngp_pkg::CH_STAR;
        cls.is_dollar = in_byte == ngp_pkg::CH_DOLLAR;
        if (cls.is_digit)
        begin
            cls.hex_ok  = 1'b1;
            cls.hex_val = in_byte[3:0];
        end
        else if (((in_byte >= 8'h41) && (in_byte <= 8'h46))
                 || ((in_byte >= 8'h61) && (in_byte <= 8'h66)))
        begin
            cls.hex_ok  = 1'b1;
            cls.hex_val = in_byte[3:0] + 4'd9;
        end
    end

    assign in_stall = cnt_reg == (PTR_W+1)'(DEPTH);
    assign push     = in_valid && !in_stall;
    assign q_valid  = cnt_reg != '0;
    assign q_beat   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

FILE: sv/ngp_num_acc.sv
`default_nettype none
module ngp_num_acc
#(
    parameter int              W       = 17,
    parameter int              K       = 3,
    parameter longint unsigned CAP_S   = 64'd99000,
    parameter longint unsigned LIMIT   = 64'd99999,
    parameter logic [W-1:0]    EMPTY   = '0,
    parameter bit              SIGN_OK = 1'b0
)
(
    input  wire logic              clk,
    input  wire ngp_pkg::num_ctl_t ctl,
    output ngp_pkg::num_act_t      act,
    output logic [W-1:0]           value
);

    localparam logic [W+3:0] INT_UNIT = (W+4)'(ngp_pkg::pow10(3'(K)));
    localparam logic [W+3:0] CAP_T    = (W+4)'(CAP_S);
    localparam logic [W-1:0] LIM_T    = W'(LIMIT);

    logic [W-1:0] acc_reg, acc_next, base, clamp, fin_val;
    logic [W+3:0] scaled;
    logic [27:0]  frac_term;

    always_comb
    begin
        base      = ctl.clear ? '0 : acc_reg;
        // integer digit: value is int part scaled by 10^K, so scale-shift by ten
        scaled    = ((W+4)'(base) << 3) + ((W+4)'(base) << 1)
                    + (W+4)'(ctl.digit) * INT_UNIT;
        frac_term = 28'(ctl.digit) * 28'(ngp_pkg::pow10(3'(K - 1) - ctl.frac_cnt));
        act       = '0;
        acc_next  = base;
        if (ctl.is_digit)
        begin
            if (ctl.point)
            begin
                if (int'(ctl.frac_cnt) < K)
                begin
                    acc_next     = base + W'(frac_term);
                    act.inc_frac = 1'b1;
                end
            end
            else
            begin
                acc_next = (scaled > CAP_T) ? W'(CAP_T) : W'(scaled);
            end
        end
        else if (ctl.is_dot && !ctl.point && (K > 0))
        begin
            act.set_point = 1'b1;
        end
        else if (ctl.lead && SIGN_OK && (ctl.is_minus || ctl.is_plus))
        begin
            act.set_sign = ctl.is_minus;
        end
        else
        begin
            act.stop = 1'b1;
        end
        clamp   = (acc_reg > LIM_T) ? LIM_T : acc_reg;
        fin_val = ctl.sign ? (W'(0) - clamp) : clamp;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_empty)
        begin
            acc_reg <= EMPTY;
        end
        else if (ctl.fin && ctl.nonempty)
        begin
            acc_reg <= fin_val;
        end
        else if (ctl.feed)
        begin
            acc_reg <= acc_next;
        end
        else if (ctl.clear)
        begin
            // field opened by a beat that this accumulator does not take
            acc_reg <= '0;
        end
    end

    assign value = acc_reg;

endmodule
`default_nettype wire

FILE: sv/ngp_back.sv
`default_nettype none
module ngp_back
#(
    parameter int FIELD_CHARS       = 20,
    parameter int ANGLE_FRAC_DIGITS = 5
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire ngp_pkg::beat_t      q_beat,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [6:0]               utc_hours,
    output logic [6:0]               utc_minutes,
    output logic [16:0]              utc_seconds_ms,
    output logic signed [30:0]       latitude_fixed,
    output logic [7:0]               lat_hemisphere,
    output logic signed [34:0]       longitude_fixed,
    output logic [7:0]               lon_hemisphere,
    output logic signed [8:0]        fix_quality,
    output logic [7:0]               satellites_used,
    output logic signed [17:0]       hdop_hundredths,
    output logic signed [27:0]       altitude_mm,
    output logic signed [24:0]       separation_mm
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HEX1 = 4'b0100,
        PH_HEX2 = 4'b1000
    } phase_t;

    localparam logic [3:0] POS_UTC  = 4'd1;
    localparam logic [3:0] POS_LAT  = 4'd2;
    localparam logic [3:0] POS_LATH = 4'd3;
    localparam logic [3:0] POS_LON  = 4'd4;
    localparam logic [3:0] POS_LONH = 4'd5;
    localparam logic [3:0] POS_QUAL = 4'd6;
    localparam logic [3:0] POS_SATS = 4'd7;
    localparam logic [3:0] POS_HDOP = 4'd8;
    localparam logic [3:0] POS_ALT  = 4'd9;
    localparam logic [3:0] POS_SEP  = 4'd11;
    localparam logic [3:0] POS_LAST = 4'd15;

    localparam int              IDX_W    = $clog2(FIELD_CHARS + 1);
    localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(FIELD_CHARS);
    localparam longint unsigned ANG_UNIT = 64'(ngp_pkg::pow10(3'(ANGLE_FRAC_DIGITS)));
    localparam int LAT_BITS = $clog2(64'd10000 * ANG_UNIT);
    localparam int LAT_W    = (LAT_BITS > 31) ? LAT_BITS : 31;
    localparam int LON_BITS = $clog2(64'd100000 * ANG_UNIT);
    localparam int LON_W    = (LON_BITS > 35) ? LON_BITS : 35;

    phase_t           phase_reg, phase_next;
    logic [7:0]       xor_reg, xor_next;
    logic [3:0]       hi_reg, hi_next;
    logic [3:0]       pos_reg, pos_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [2:0]       frac_reg, frac_next;
    logic             point_reg, point_next, sign_reg, sign_next, ne_reg, ne_next;
    logic [6:0]       hh_reg, hh_next, mm_reg, mm_next;
    logic [7:0]       lath_reg, lath_next, lonh_reg, lonh_next, qual_reg, qual_next;
    logic             out_valid_reg;

    logic             emit, load_empty, fin, feed, first, sec_start, pt_eff, sg_eff;
    logic             pair_pt, in_pair;

    ngp_pkg::num_ctl_t ctl_base, ctl_sec, ctl_lat, ctl_lon, ctl_sats, ctl_hdop;
    ngp_pkg::num_ctl_t ctl_alt, ctl_sep;
    ngp_pkg::num_act_t act_sec, act_lat, act_lon, act_sats, act_hdop, act_alt, act_sep;
    ngp_pkg::num_act_t act;

    logic [16:0]      sec_val;
    logic [LAT_W-1:0] lat_val;
    logic [LON_W-1:0] lon_val;
    logic [7:0]       sats_val;
    logic [17:0]      hdop_val;
    logic [27:0]      alt_val;
    logic [24:0]      sep_val;

    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    assign first     = idx_reg == '0;
    assign sec_start = (pos_reg == POS_UTC) && (idx_reg == IDX_W'(4));
    assign in_pair   = (pos_reg == POS_UTC) && (idx_reg < IDX_W'(4));
    // seconds restart the number flags; minutes restart the pair stop flag
    assign pt_eff    = sec_start ? 1'b0 : point_reg;
    assign sg_eff    = sec_start ? 1'b0 : sign_reg;
    assign pair_pt   = (idx_reg == IDX_W'(2)) ? 1'b0 : point_reg;

    always_comb
    begin
        ctl_base            = '0;
        ctl_base.load_empty = load_empty;
        ctl_base.lead       = first;
        ctl_base.point      = pt_eff;
        ctl_base.sign       = sign_reg;
        ctl_base.nonempty   = ne_reg;
        ctl_base.frac_cnt   = frac_reg;
        ctl_base.is_digit   = q_beat.is_digit;
        ctl_base.digit      = q_beat.ch[3:0];
        ctl_base.is_dot     = q_beat.is_dot;
        ctl_base.is_minus   = q_beat.is_minus;
        ctl_base.is_plus    = q_beat.is_plus;

        ctl_sec       = ctl_base;
        ctl_sec.lead  = sec_start;
        ctl_sec.feed  = feed && (pos_reg == POS_UTC) && !in_pair;
        ctl_sec.clear = feed && (pos_reg == POS_UTC) && first;
        ctl_sec.fin   = fin && (pos_reg == POS_UTC);

        ctl_lat       = ctl_base;
        ctl_lat.feed  = feed && (pos_reg == POS_LAT);
        ctl_lat.clear = ctl_lat.feed && first;
        ctl_lat.fin   = fin && (pos_reg == POS_LAT);

        ctl_lon       = ctl_base;
        ctl_lon.feed  = feed && (pos_reg == POS_LON);
        ctl_lon.clear = ctl_lon.feed && first;
        ctl_lon.fin   = fin && (pos_reg == POS_LON);

        ctl_sats       = ctl_base;
        ctl_sats.feed  = feed && (pos_reg == POS_SATS);
        ctl_sats.clear = ctl_sats.feed && first;
        ctl_sats.fin   = fin && (pos_reg == POS_SATS);

        ctl_hdop       = ctl_base;
        ctl_hdop.feed  = feed && (pos_reg == POS_HDOP);
        ctl_hdop.clear = ctl_hdop.feed && first;
        ctl_hdop.fin   = fin && (pos_reg == POS_HDOP);

        ctl_alt       = ctl_base;
        ctl_alt.feed  = feed && (pos_reg == POS_ALT);
        ctl_alt.clear = ctl_alt.feed && first;
        ctl_alt.fin   = fin && (pos_reg == POS_ALT);

        ctl_sep       = ctl_base;
        ctl_sep.feed  = feed && (pos_reg == POS_SEP);
        ctl_sep.clear = ctl_sep.feed && first;
        ctl_sep.fin   = fin && (pos_reg == POS_SEP);
    end

    ngp_num_acc #(.W(17), .K(3), .CAP_S(64'd99000), .LIMIT(64'd99999),
                  .EMPTY('0), .SIGN_OK(1'b0))
        u_sec (.clk(clk), .ctl(ctl_sec), .act(act_sec), .value(sec_val));

    ngp_num_acc #(.W(LAT_W), .K(ANGLE_FRAC_DIGITS), .CAP_S(64'd9999 * ANG_UNIT),
                  .LIMIT(64'd1073741823), .EMPTY('1), .SIGN_OK(1'b0))
        u_lat (.clk(clk), .ctl(ctl_lat), .act(act_lat), .value(lat_val));

    ngp_num_acc #(.W(LON_W), .K(ANGLE_FRAC_DIGITS), .CAP_S(64'd99999 * ANG_UNIT),
                  .LIMIT(64'd17179869183), .EMPTY('1), .SIGN_OK(1'b0))
        u_lon (.clk(clk), .ctl(ctl_lon), .act(act_lon), .value(lon_val));

    ngp_num_acc #(.W(8), .K(0), .CAP_S(64'd255), .LIMIT(64'd255),
                  .EMPTY('0), .SIGN_OK(1'b0))
        u_sats (.clk(clk), .ctl(ctl_sats), .act(act_sats), .value(sats_val));

    ngp_num_acc #(.W(18), .K(2), .CAP_S(64'd99900), .LIMIT(64'd99999),
                  .EMPTY('1), .SIGN_OK(1'b0))
        u_hdop (.clk(clk), .ctl(ctl_hdop), .act(act_hdop), .value(hdop_val));

    ngp_num_acc #(.W(28), .K(3), .CAP_S(64'd99999000), .LIMIT(64'd99999999),
                  .EMPTY(28'(-100000000)), .SIGN_OK(1'b1))
        u_alt (.clk(clk), .ctl(ctl_alt), .act(act_alt), .value(alt_val));

    ngp_num_acc #(.W(25), .K(3), .CAP_S(64'd9999000), .LIMIT(64'd9999999),
                  .EMPTY(25'(-10000000)), .SIGN_OK(1'b1))
        u_sep (.clk(clk), .ctl(ctl_sep), .act(act_sep), .value(sep_val));

    always_comb
    begin
        case (pos_reg)
            POS_UTC:  act = in_pair ? '0 : act_sec;
            POS_LAT:  act = act_lat;
            POS_LON:  act = act_lon;
            POS_SATS: act = act_sats;
            POS_HDOP: act = act_hdop;
            POS_ALT:  act = act_alt;
            POS_SEP:  act = act_sep;
            default:  act = '0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        hi_next    = hi_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        frac_next  = frac_reg;
        point_next = point_reg;
        sign_next  = sign_reg;
        ne_next    = ne_reg;
        hh_next    = hh_reg;
        mm_next    = mm_reg;
        lath_next  = lath_reg;
        lonh_next  = lonh_reg;
        qual_next  = qual_reg;
        emit       = 1'b0;
        load_empty = 1'b0;
        fin        = 1'b0;
        feed       = 1'b0;
        if (q_pop)
        begin
            if (q_beat.is_dollar)
            begin
                load_empty = 1'b1;
                phase_next = PH_BODY;
                xor_next   = '0;
                hi_next    = '0;
                pos_next   = '0;
                idx_next   = '0;
                frac_next  = '0;
                point_next = 1'b0;
                sign_next  = 1'b0;
                ne_next    = 1'b0;
                hh_next    = '0;
                mm_next    = '0;
                lath_next  = '0;
                lonh_next  = '0;
                qual_next  = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_BODY:
                    begin
                        if (q_beat.is_star || q_beat.is_comma)
                        begin
                            fin        = 1'b1;
                            idx_next   = '0;
                            frac_next  = '0;
                            point_next = 1'b0;
                            sign_next  = 1'b0;
                            ne_next    = 1'b0;
                        end
                        if (q_beat.is_star)
                        begin
                            phase_next = PH_HEX2 == PH_HEX2 ? PH_HEX1 : PH_HEX1;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ q_beat.ch;
                            if (q_beat.is_comma)
                            begin
                                if (pos_reg != POS_LAST)
                                begin
                                    pos_next = pos_reg + 4'd1;
                                end
                            end
                            else if (idx_reg < IDX_FULL)
                            begin
                                feed     = 1'b1;
                                ne_next  = 1'b1;
                                idx_next = idx_reg + 1'b1;
                                if (in_pair)
                                begin
                                    if (q_beat.is_digit && !pair_pt)
                                    begin
                                        if (idx_reg < IDX_W'(2))
                                        begin
                                            hh_next = (first ? 7'd0 : hh_reg) * 7'd10
                                                      + 7'(q_beat.ch[3:0]);
                                        end
                                        else
                                        begin
                                            mm_next = mm_reg * 7'd10 + 7'(q_beat.ch[3:0]);
                                        end
                                        point_next = pair_pt;
                                    end
                                    else
                                    begin
                                        if (first)
                                        begin
                                            hh_next = '0;
                                        end
                                        point_next = 1'b1;
                                    end
                                    if (first)
                                    begin
                                        mm_next = '0;
                                    end
                                end
                                else
                                begin
                                    point_next = pt_eff | act.set_point;
                                    sign_next  = sg_eff | act.set_sign;
                                    frac_next  = frac_reg + 3'(act.inc_frac);
                                    if (act.stop)
                                    begin
                                        idx_next = IDX_FULL;
                                    end
                                end
                                if (first)
                                begin
                                    case (pos_reg)
                                        POS_LATH: lath_next = q_beat.ch;
                                        POS_LONH: lonh_next = q_beat.ch;
                                        POS_QUAL: qual_next = q_beat.ch;
                                        default:  ;
                                    endcase
                                end
                            end
                        end
                    end
                    PH_HEX1:
                    begin
                        if (q_beat.hex_ok)
                        begin
                            hi_next    = q_beat.hex_val;
                            phase_next = PH_HEX2;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_HEX2:
                    begin
                        phase_next = PH_IDLE;
                        emit = q_beat.hex_ok && ({hi_reg, q_beat.hex_val} == xor_reg);
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            xor_reg       <= '0;
            hi_reg        <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            frac_reg      <= '0;
            point_reg     <= 1'b0;
            sign_reg      <= 1'b0;
            ne_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            hi_reg    <= hi_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            frac_reg  <= frac_next;
            point_reg <= point_next;
            sign_reg  <= sign_next;
            ne_reg    <= ne_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hh_reg   <= hh_next;
        mm_reg   <= mm_next;
        lath_reg <= lath_next;
        lonh_reg <= lonh_next;
        qual_reg <= qual_next;
        if (emit)
        begin
            utc_hours       <= hh_reg;
            utc_minutes     <= mm_reg;
            utc_seconds_ms  <= sec_val;
            latitude_fixed  <= lat_val[30:0];
            lat_hemisphere  <= lath_reg;
            longitude_fixed <= lon_val[34:0];
            lon_hemisphere  <= lonh_reg;
            fix_quality     <= {1'b0, qual_reg} - 9'(ngp_pkg::CH_ZERO);
            satellites_used <= sats_val;
            hdop_hundredths <= hdop_val;
            altitude_mm     <= alt_val;
            separation_mm   <= sep_val;
        end
    end

    assign out_valid = out_valid_reg;

    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !(out_valid_reg && out_stall))
        else $error("beat taken while result held");

    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (phase_reg == PH_HEX2) && q_pop)
        else $error("result outside checksum phase");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_FULL)
        else $error("field char count out of range");

    a_dollar: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_beat.is_dollar) |=> (phase_reg == PH_BODY) && (pos_reg == '0)
                                        && (xor_reg == '0))
        else $error("sentence start not taken");

endmodule
`default_nettype wire

FILE: sv/nmea_gga_sentence_parser_core.sv
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | in_byte
// out      | out_valid / out_stall| utc_*, latitude/longitude, hemispheres,
//          |                      | fix_quality, satellites, hdop, alt, sep
//
// one beat per cycle sustained while out_stall does not hold a result; a byte is
// registered in the classifier queue, and the field sequencer registers the result
// when it takes the second checksum digit
// the two-entry queue decouples input from output; in_stall rises only
// when the queue is full while the result register is held by out_stall
// rst_n clears phase and handshake state; field payload needs a '$' first
`default_nettype none
module nmea_gga_sentence_parser_core
#(
    parameter int FIELD_CHARS       = 20,
    parameter int ANGLE_FRAC_DIGITS = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    in_byte,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [6:0]         utc_hours,
    output logic [6:0]         utc_minutes,
    output logic [16:0]        utc_seconds_ms,
    output logic signed [30:0] latitude_fixed,
    output logic [7:0]         lat_hemisphere,
    output logic signed [34:0] longitude_fixed,
    output logic [7:0]         lon_hemisphere,
    output logic signed [8:0]  fix_quality,
    output logic [7:0]         satellites_used,
    output logic signed [17:0] hdop_hundredths,
    output logic signed [27:0] altitude_mm,
    output logic signed [24:0] separation_mm
);

    logic           q_valid, q_pop;
    ngp_pkg::beat_t q_beat;

    ngp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .q_valid  (q_valid),
        .q_beat   (q_beat),
        .q_pop    (q_pop)
    );

    ngp_back #(.FIELD_CHARS(FIELD_CHARS), .ANGLE_FRAC_DIGITS(ANGLE_FRAC_DIGITS)) u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_beat          (q_beat),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .utc_hours       (utc_hours),
        .utc_minutes     (utc_minutes),
        .utc_seconds_ms  (utc_seconds_ms),
        .latitude_fixed  (latitude_fixed),
        .lat_hemisphere  (lat_hemisphere),
        .longitude_fixed (longitude_fixed),
        .lon_hemisphere  (lon_hemisphere),
        .fix_quality     (fix_quality),
        .satellites_used (satellites_used),
        .hdop_hundredths (hdop_hundredths),
        .altitude_mm     (altitude_mm),
        .separation_mm   (separation_mm)
    );

endmodule
`default_nettype wire
